// ----- src/ptt_pkg.sv -----
// ---------------------------------------------------------------------------
// ptt_pkg
// Shared types and codes for the priority task table.
// ---------------------------------------------------------------------------
package ptt_pkg;
    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_MARK   = 2'd2;
    localparam logic [1:0] ACT_QUERY  = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_PRIO = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_BAD_POS  = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;

    localparam logic [2:0] PRIO_LOW = 3'd1;
    localparam logic [2:0] PRIO_TOP = 3'd5;

    // Operation broadcast to every cell.
    localparam logic [1:0] OP_HOLD   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [2:0]  prio;
        logic [15:0] tm;
    } t_cmd;

    // Entry passed between neighbor cells.
    typedef struct packed {
        logic [2:0]  prio;
        logic [15:0] tm;
    } t_entry;
endpackage

// ----- src/ptt_cell.sv -----
// ---------------------------------------------------------------------------
// ptt_cell
// One table slot: holds an entry, shifts toward or from its neighbors.
// ---------------------------------------------------------------------------
module ptt_cell
    import ptt_pkg::*;
(
    input  logic   i_clk,
    input  t_cmd   i_cmd,
    input  logic   i_ins_here,   // insertion slot is this cell
    input  logic   i_ins_after,  // insertion slot is before this cell
    input  logic   i_del_after,  // deleted slot is at or before this cell
    input  t_entry i_prev,
    input  t_entry i_next,
    output t_entry o_entry
);
    t_entry r_entry;
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_INSERT) begin
            if (i_ins_here) begin
                r_entry <= '{prio: i_cmd.prio, tm: i_cmd.tm};
            end else if (i_ins_after) begin
                r_entry <= i_prev;
            end
        end else if (i_cmd.op == OP_DELETE && i_del_after) begin
            r_entry <= i_next;
        end
    end
    assign o_entry = r_entry;
endmodule

// ----- src/priority_task_table_core.sv -----
// ---------------------------------------------------------------------------
// priority_task_table_core
// Sorted task table built from a chain of shift cells.
// ---------------------------------------------------------------------------
// Input channel: i_valid/o_stall carry one request transaction (action,
// priority, time, position). Output channel: o_valid/i_stall carry exactly
// one result transaction per request.
// A request is registered when accepted and resolved in the following
// cycle (slot search, mark-off scan over the leading run, tallies); its
// result is registered at the end of that cycle. The cell row shifts at
// the same edge that registers the result.
// A new request is not taken while the last one is resolving; the next
// request may enter in the cycle the result leaves.
// The mark-off scan is a tree of compares across the cell outputs.
// Reset clears the count, tallies and total time; cell contents are
// meaningless until written and are never read beyond the count.
// When the receiver stalls, the result holds and the block takes no
// further request until it drains.
// ---------------------------------------------------------------------------
module priority_task_table_core
    import ptt_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_action,
    input  logic [2:0]  i_task_priority,
    input  logic [15:0] i_task_time,
    input  logic [5:0]  i_position,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [2:0]  o_out_priority,
    output logic [15:0] o_out_time,
    output logic [5:0]  o_out_position,
    output logic [5:0]  o_task_count,
    output logic [5:0]  o_priority_count,
    output logic [20:0] o_total_time
);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam int PW = (CW > 7) ? CW : 7;
    localparam int NP = 1 << IW;

    // request register
    logic        r_busy;
    logic [1:0]  r_act;
    logic [2:0]  r_prio;
    logic [15:0] r_tm;
    logic [5:0]  r_pos;

    logic [CW-1:0] r_count;
    logic [CW-1:0] r_pcnt [5];
    logic [20:0]   r_sum;

    t_entry w_ent [DEPTH];
    t_cmd   w_cmd;
    logic [DEPTH-1:0] w_ins_here, w_ins_after, w_del_after;

    // take a new request while resolving nothing and the result slot frees
    assign o_stall = r_busy || (o_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
        if (i_valid && !o_stall) begin
            r_act  <= i_action;
            r_prio <= i_task_priority;
            r_tm   <= i_task_time;
            r_pos  <= i_position;
        end
    end

    // decisions
    logic          w_prio_ok, w_empty, w_full;
    logic [CW-1:0] w_slot, w_del_idx, w_best;
    logic          w_do_add, w_do_del;
    logic [2:0]    w_status;

    assign w_prio_ok = (r_prio >= PRIO_LOW) && (r_prio <= PRIO_TOP);
    assign w_empty   = (r_count == '0);
    assign w_full    = (r_count >= CW'(DEPTH));

    // slot: first position whose priority is at most the new one, with the
    // front and back shortcuts of the table ordering.
    logic [IW-1:0] w_last_idx;
    assign w_last_idx = IW'(r_count - CW'(1));
    always_comb begin
        logic found;
        found  = 1'b0;
        w_slot = r_count;
        if (w_empty || w_ent[0].prio <= r_prio) begin
            w_slot = '0;
        end else if (w_ent[w_last_idx].prio >= r_prio) begin
            w_slot = r_count;
        end else begin
            for (int i = 1; i < DEPTH; i++) begin
                if (!found && CW'(i) < r_count && w_ent[i].prio <= r_prio) begin
                    found  = 1'b1;
                    w_slot = CW'(i);
                end
            end
        end
    end

    // mark-off: shortest time among entries sharing the top priority; the
    // table is sorted, so those form the leading run. Reduce pairwise, the
    // lower half winning ties so the earliest entry is kept.
    always_comb begin
        logic          nv   [2*NP];
        logic [15:0]   ntm  [2*NP];
        logic [IW-1:0] nidx [2*NP];
        for (int k = 0; k < 2 * NP; k++) begin
            nv[k]   = 1'b0;
            ntm[k]  = '0;
            nidx[k] = '0;
        end
        for (int i = 0; i < DEPTH; i++) begin
            nv[NP + i]   = (CW'(i) < r_count) && (w_ent[i].prio == w_ent[0].prio);
            ntm[NP + i]  = w_ent[i].tm;
            nidx[NP + i] = IW'(i);
        end
        for (int k = NP - 1; k >= 1; k--) begin
            if (nv[2*k] && (!nv[2*k+1] || ntm[2*k] <= ntm[2*k+1])) begin
                nv[k]   = 1'b1;
                ntm[k]  = ntm[2*k];
                nidx[k] = nidx[2*k];
            end else begin
                nv[k]   = nv[2*k+1];
                ntm[k]  = ntm[2*k+1];
                nidx[k] = nidx[2*k+1];
            end
        end
        w_best = CW'(nidx[1]);
    end

    always_comb begin
        w_status  = ST_OK;
        w_do_add  = 1'b0;
        w_do_del  = 1'b0;
        w_del_idx = w_best;
        unique case (r_act)
            ACT_ADD: begin
                if (!w_prio_ok)  w_status = ST_BAD_PRIO;
                else if (w_full) w_status = ST_FULL;
                else             w_do_add = 1'b1;
            end
            ACT_REMOVE: begin
                w_del_idx = CW'(r_pos - 6'd1);
                if (w_empty) w_status = ST_EMPTY;
                else if (r_pos == 6'd0 || PW'(r_pos) > PW'(r_count)) w_status = ST_BAD_POS;
                else w_do_del = 1'b1;
            end
            ACT_MARK: begin
                if (w_empty) w_status = ST_EMPTY;
                else         w_do_del = 1'b1;
            end
            ACT_QUERY: begin
                if (!w_prio_ok) w_status = ST_BAD_PRIO;
            end
            default: w_status = ST_OK;
        endcase
    end

    t_entry w_del_ent;
    assign w_del_ent = w_ent[IW'(w_del_idx)];

    // cell chain control
    always_comb begin
        w_cmd.op   = OP_HOLD;
        w_cmd.prio = r_prio;
        w_cmd.tm   = r_tm;
        if (r_busy && w_do_add) w_cmd.op = OP_INSERT;
        if (r_busy && w_do_del) w_cmd.op = OP_DELETE;
        for (int i = 0; i < DEPTH; i++) begin
            w_ins_here[i]  = (CW'(i) == w_slot);
            w_ins_after[i] = (CW'(i) > w_slot);
            w_del_after[i] = (CW'(i) >= w_del_idx);
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        ptt_cell u_cell (
            .i_clk      (i_clk),
            .i_cmd      (w_cmd),
            .i_ins_here (w_ins_here[g]),
            .i_ins_after(w_ins_after[g]),
            .i_del_after(w_del_after[g]),
            .i_prev     (w_ent[(g == 0) ? 0 : g - 1]),
            .i_next     (w_ent[(g == DEPTH - 1) ? g : g + 1]),
            .o_entry    (w_ent[g])
        );
    end

    // tallies and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
            for (int k = 0; k < 5; k++) r_pcnt[k] <= '0;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && !i_stall) o_valid <= 1'b0;
            if (r_busy) begin
                logic [CW-1:0] nc;
                logic [20:0]   ns;
                nc = r_count;
                ns = r_sum;
                o_valid          <= 1'b1;
                o_status         <= w_status;
                o_out_priority   <= '0;
                o_out_time       <= '0;
                o_out_position   <= '0;
                o_priority_count <= '0;
                if (w_do_add) begin
                    nc = r_count + CW'(1);
                    ns = r_sum + 21'(r_tm);
                    r_pcnt[r_prio - 3'd1] <= r_pcnt[r_prio - 3'd1] + CW'(1);
                end
                if (w_do_del) begin
                    nc = r_count - CW'(1);
                    ns = r_sum - 21'(w_del_ent.tm);
                    if (w_del_ent.prio >= PRIO_LOW && w_del_ent.prio <= PRIO_TOP)
                        r_pcnt[w_del_ent.prio - 3'd1] <= r_pcnt[w_del_ent.prio - 3'd1] - CW'(1);
                    o_out_priority <= w_del_ent.prio;
                    o_out_time     <= w_del_ent.tm;
                    o_out_position <= 6'(w_del_idx + CW'(1));
                end
                if (r_act == ACT_QUERY && w_prio_ok)
                    o_priority_count <= 6'(r_pcnt[r_prio - 3'd1]);
                r_count      <= nc;
                r_sum        <= ns;
                o_task_count <= 6'(nc);
                o_total_time <= ns;
            end
        end
    end

    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_do_add && w_do_del)) else $error("add and delete together");
    a_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH)) else $error("count above depth");
    a_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> o_valid) else $error("result missing");
    a_nobusy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_busy && o_valid)) else $error("overlap");
endmodule

// ----- verif/tb_priority_task_table_core.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_priority_task_table_core
// Self-checking bench for the sorted task table core.
// ---------------------------------------------------------------------------
// A queue of request transactions feeds a clocked driver; a clocked monitor
// checks each result transaction against a local model of the sorted table
// that is updated as each request is accepted. Idling runs in three phases,
// with a long output hold-off and a full drain pause along the way.
// ---------------------------------------------------------------------------
module tb_priority_task_table_core;
    import ptt_pkg::*;

    localparam int TBL_DEPTH = 32;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic [1:0]  action;
        logic [2:0]  prio;
        logic [15:0] tm;
        logic [5:0]  pos;
    } t_request;

    typedef struct {
        logic [2:0]  status;
        logic [2:0]  out_prio;
        logic [15:0] out_time;
        logic [5:0]  out_pos;
        logic [5:0]  task_count;
        logic [5:0]  prio_count;
        logic [20:0] total_time;
    } t_outcome;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_action;
    logic [2:0]  i_task_priority;
    logic [15:0] i_task_time;
    logic [5:0]  i_position;
    logic        o_valid;
    logic        i_stall;
    logic [2:0]  o_status;
    logic [2:0]  o_out_priority;
    logic [15:0] o_out_time;
    logic [5:0]  o_out_position;
    logic [5:0]  o_task_count;
    logic [5:0]  o_priority_count;
    logic [20:0] o_total_time;

    priority_task_table_core #(.DEPTH(TBL_DEPTH)) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_action        (i_action),
        .i_task_priority (i_task_priority),
        .i_task_time     (i_task_time),
        .i_position      (i_position),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_out_priority  (o_out_priority),
        .o_out_time      (o_out_time),
        .o_out_position  (o_out_position),
        .o_task_count    (o_task_count),
        .o_priority_count(o_priority_count),
        .o_total_time    (o_total_time)
    );

    // Clock: 10 ns period.
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Model of the table contents and its tallies.
    logic [2:0]  tbl_prio [TBL_DEPTH];
    logic [15:0] tbl_time [TBL_DEPTH];
    int          tbl_count;
    int          prio_tally [1:5];
    logic [20:0] time_sum;

    t_request pending_requests[$];
    t_outcome expected_results[$];

    int  sender_idle_pct;
    int  receiver_idle_pct;
    int  holdoff_cycles;   // long receiver hold-off, counted by the monitor
    bit  sender_pause;     // drain pause requested by the stimulus block
    int  error_count;
    int  result_count;
    int  idle_cycles;
    int  n_adds, n_removes, n_marks, n_queries, n_full, n_bad;

    // Remove entry idx from the model, fill the removed fields of r.
    function automatic void drop_task(int idx, ref t_outcome r);
        r.out_prio = tbl_prio[idx];
        r.out_time = tbl_time[idx];
        r.out_pos  = 6'(idx + 1);
        prio_tally[tbl_prio[idx]]--;
        time_sum = time_sum - 21'(tbl_time[idx]);
        for (int i = idx; i + 1 < tbl_count; i++) begin
            tbl_prio[i] = tbl_prio[i + 1];
            tbl_time[i] = tbl_time[i + 1];
        end
        tbl_count--;
    endfunction

    // Apply one accepted request to the model and return its result.
    function automatic t_outcome apply_request(t_request q);
        t_outcome r;
        int       slot;
        int       best;
        r = '{default: '0};
        r.status = ST_OK;
        case (q.action)
            ACT_ADD: begin
                if (q.prio < PRIO_LOW || q.prio > PRIO_TOP) begin
                    r.status = ST_BAD_PRIO;
                    n_bad++;
                end else if (tbl_count >= TBL_DEPTH) begin
                    r.status = ST_FULL;
                    n_full++;
                end else begin
                    if (tbl_count == 0 || tbl_prio[0] <= q.prio) begin
                        slot = 0;
                    end else if (tbl_prio[tbl_count - 1] >= q.prio) begin
                        slot = tbl_count;
                    end else begin
                        slot = 1;
                        while (slot < tbl_count && tbl_prio[slot] > q.prio) slot++;
                    end
                    for (int i = tbl_count; i > slot; i--) begin
                        tbl_prio[i] = tbl_prio[i - 1];
                        tbl_time[i] = tbl_time[i - 1];
                    end
                    tbl_prio[slot] = q.prio;
                    tbl_time[slot] = q.tm;
                    tbl_count++;
                    prio_tally[q.prio]++;
                    time_sum = time_sum + 21'(q.tm);
                    n_adds++;
                end
            end
            ACT_REMOVE: begin
                if (tbl_count == 0) begin
                    r.status = ST_EMPTY;
                end else if (q.pos == 0 || q.pos > tbl_count) begin
                    r.status = ST_BAD_POS;
                end else begin
                    drop_task(int'(q.pos) - 1, r);
                    n_removes++;
                end
            end
            ACT_MARK: begin
                if (tbl_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    best = 0;
                    for (int i = 1; i < tbl_count && tbl_prio[i] == tbl_prio[0]; i++)
                        if (tbl_time[i] < tbl_time[best]) best = i;
                    drop_task(best, r);
                    n_marks++;
                end
            end
            default: begin
                if (q.prio < PRIO_LOW || q.prio > PRIO_TOP) r.status = ST_BAD_PRIO;
                else r.prio_count = 6'(prio_tally[q.prio]);
                n_queries++;
            end
        endcase
        r.task_count = 6'(tbl_count);
        r.total_time = time_sum;
        return r;
    endfunction

    function automatic void push_request(logic [1:0] a, logic [2:0] p,
                                         logic [15:0] t, logic [5:0] s);
        t_request q;
        q.action = a;
        q.prio   = p;
        q.tm     = t;
        q.pos    = s;
        pending_requests.push_back(q);
    endfunction

    // Random request; mostly valid fields, weighted to keep the table busy.
    function automatic void push_random(int add_weight);
        int          sel;
        logic [2:0]  p;
        logic [5:0]  s;
        sel = $urandom_range(0, 99);
        p = ($urandom_range(0, 9) == 0) ? 3'($urandom) : 3'($urandom_range(1, 5));
        s = ($urandom_range(0, 7) == 0) ? 6'($urandom) : 6'($urandom_range(1, 33));
        if (sel < add_weight) push_request(ACT_ADD, p, 16'($urandom), s);
        else if (sel < add_weight + 20) push_request(ACT_REMOVE, p, 16'($urandom), s);
        else if (sel < add_weight + 40) push_request(ACT_MARK, p, 16'($urandom), s);
        else push_request(ACT_QUERY, p, 16'($urandom), s);
    endfunction

    // Driver: present the head of the queue, advance on acceptance. The model
    // is updated at acceptance so the expectation order matches.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!(i_valid && o_stall)) begin
            // Current transaction accepted or none offered: pick the next one.
            if (i_valid)
                expected_results.push_back(apply_request(pending_requests.pop_front()));
            if (pending_requests.size() > 0 && !sender_pause &&
                $urandom_range(0, 99) >= sender_idle_pct) begin
                i_valid         <= 1'b1;
                i_action        <= pending_requests[0].action;
                i_task_priority <= pending_requests[0].prio;
                i_task_time     <= pending_requests[0].tm;
                i_position      <= pending_requests[0].pos;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Monitor: check accepted results, drive the output stall.
    always @(posedge i_clk) begin
        t_outcome e;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                result_count++;
                if (expected_results.size() == 0) begin
                    $error("result with no request outstanding");
                    error_count++;
                end else begin
                    e = expected_results.pop_front();
                    if (o_status !== e.status) begin
                        $error("status exp %0d got %0d", e.status, o_status);
                        error_count++;
                    end
                    if (o_out_priority !== e.out_prio) begin
                        $error("out_priority exp %0d got %0d", e.out_prio, o_out_priority);
                        error_count++;
                    end
                    if (o_out_time !== e.out_time) begin
                        $error("out_time exp %0d got %0d", e.out_time, o_out_time);
                        error_count++;
                    end
                    if (o_out_position !== e.out_pos) begin
                        $error("out_position exp %0d got %0d", e.out_pos, o_out_position);
                        error_count++;
                    end
                    if (o_task_count !== e.task_count) begin
                        $error("task_count exp %0d got %0d", e.task_count, o_task_count);
                        error_count++;
                    end
                    if (o_priority_count !== e.prio_count) begin
                        $error("priority_count exp %0d got %0d", e.prio_count,
                               o_priority_count);
                        error_count++;
                    end
                    if (o_total_time !== e.total_time) begin
                        $error("total_time exp %0d got %0d", e.total_time, o_total_time);
                        error_count++;
                    end
                end
            end
            if (holdoff_cycles > 0) begin
                holdoff_cycles <= holdoff_cycles - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
            end
        end
    end

    // Watchdog: count cycles in which neither side moves a transaction.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("[priority_task_table_core] ERROR");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_requests.size() != 0 || expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        int guard;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_action = ACT_QUERY;
        i_task_priority = '0;
        i_task_time = '0;
        i_position = '0;
        sender_idle_pct = 26;
        receiver_idle_pct = 80;
        holdoff_cycles = 0;
        sender_pause = 1'b0;
        error_count = 0;
        result_count = 0;
        idle_cycles = 0;
        tbl_count = 0;
        time_sum = '0;
        n_adds = 0; n_removes = 0; n_marks = 0; n_queries = 0; n_full = 0; n_bad = 0;
        for (int p = 1; p <= 5; p++) prio_tally[p] = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty-table errors, bad priorities, extremes, ordering.
        push_request(ACT_REMOVE, 3'd1, 16'd0, 6'd1);
        push_request(ACT_MARK,   3'd1, 16'd0, 6'd0);
        push_request(ACT_QUERY,  3'd0, 16'd0, 6'd0);
        push_request(ACT_ADD,    3'd0, 16'hFFFF, 6'd0);
        push_request(ACT_ADD,    3'd6, 16'd1, 6'd0);
        push_request(ACT_ADD,    3'd7, 16'd1, 6'd63);
        push_request(ACT_ADD,    3'd3, 16'hFFFF, 6'd0);
        push_request(ACT_ADD,    3'd5, 16'd0, 6'd0);
        push_request(ACT_ADD,    3'd1, 16'd7, 6'd0);
        push_request(ACT_ADD,    3'd4, 16'd9, 6'd0);   // lands mid-table
        push_request(ACT_ADD,    3'd5, 16'd0, 6'd0);   // tie with earlier top
        push_request(ACT_ADD,    3'd2, 16'd3, 6'd0);
        push_request(ACT_QUERY,  3'd5, 16'd0, 6'd0);
        push_request(ACT_QUERY,  3'd7, 16'd0, 6'd0);
        push_request(ACT_REMOVE, 3'd0, 16'd0, 6'd0);
        push_request(ACT_REMOVE, 3'd0, 16'd0, 6'd63);
        push_request(ACT_REMOVE, 3'd0, 16'd0, 6'd6);
        push_request(ACT_MARK,   3'd0, 16'd0, 6'd0);
        push_request(ACT_REMOVE, 3'd0, 16'd0, 6'd1);
        // Fill past capacity with maximal times; the surplus adds cover the full case.
        for (int i = 0; i < TBL_DEPTH + 2; i++)
            push_request(ACT_ADD, 3'($urandom_range(1, 5)), 16'hFFFF, 6'd0);
        push_request(ACT_QUERY, 3'd1, 16'd0, 6'd0);
        wait_drained();

        // Phase 1: sender idles lightly, receiver heavily.
        for (int i = 0; i < 500; i++) push_random(30);
        // Long receiver hold-off while the sender keeps offering.
        holdoff_cycles = 300;
        wait_drained();

        // Drain pause: hold the sender while new requests are queued, then release it.
        sender_pause = 1'b1;
        for (int i = 0; i < 20; i++) push_random(45);
        repeat (50) @(posedge i_clk);
        sender_pause = 1'b0;

        // Phase 2: swap idling.
        sender_idle_pct = 80;
        receiver_idle_pct = 26;
        for (int i = 0; i < 550; i++) push_random(i < 275 ? 55 : 25);
        wait_drained();

        // Phase 3: full rate both sides.
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        for (int i = 0; i < 600; i++) push_random(i < 300 ? 50 : 30);
        wait_drained();

        guard = 0;
        while (o_valid && guard < 100) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (10) @(posedge i_clk);

        $display("covered %0d results: %0d adds, %0d removes, %0d mark-offs, %0d queries",
                 result_count, n_adds, n_removes, n_marks, n_queries);
        $display("full-table rejects %0d, bad-priority adds %0d", n_full, n_bad);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("[priority_task_table_core] OK");
        end else begin
            $display("[priority_task_table_core] ERROR");
        end
        $finish;
    end
endmodule

// ----- priority_task_table_core.f -----
src/ptt_pkg.sv
src/ptt_cell.sv
src/priority_task_table_core.sv
verif/tb_priority_task_table_core.sv
